// ----- design/epc_pkg.sv -----
// Shared types, constants and helper functions for the extension pattern classifier.
// Used by epc_cell, extension_pattern_classifier and epc_checker.
package epc_pkg;

  localparam int BYTE_W    = 8;
  localparam int PAT_BYTES = 4;
  localparam int PAT_W     = PAT_BYTES * BYTE_W;
  localparam int LEN_W     = 3;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_COUNT = 5;

  localparam logic [BYTE_W-1:0] DOT_CHAR    = 8'h2E;
  localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_ZERO  = 3'd0,
    REG_PATTERN_ONE   = 3'd1,
    REG_PATTERN_TWO   = 3'd2,
    REG_PATTERN_THREE = 3'd3,
    REG_PATTERN_FOUR  = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_COUNT-1:0][PAT_W-1:0] PATTERN_RESET = {
    32'd1885496695,
    32'd6711655,
    32'd6778480,
    32'd1734701162,
    32'd6778986
  };

  typedef struct packed {
    logic [BYTE_W-1:0] char_in;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] format_index;
  } out_item_t;

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pat_len(input logic [PAT_W-1:0] pat,
                                               input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] len;
    logic             stop;
    len  = '0;
    stop = 1'b0;
    for (int k = 0; k < PAT_BYTES; k++) begin
      if (!stop && LEN_W'(k) < max_len && pat[k*BYTE_W +: BYTE_W] != '0) begin
        len = len + LEN_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
    return len;
  endfunction

endpackage

// ----- design/extension_pattern_classifier.sv -----
// Top level of the extension pattern classifier: config registers, cell row, flag stage.
// Depends on epc_pkg and epc_cell; epc_checker binds to it.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data   (char_in, is_last)
//  out     | output    | out_valid / out_ready | out_data  (found, format_index)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle unless input stalls; a result passes the flag stage, then out_data.
// Row shifts on accepts from a dot on; the flag stage then compares the row, updates flags.
// Reset is synchronous; patterns return to jpg, jpeg, png, gif, webp.
// A pending result stalls input only while the output register is full and not taken.
// cfg_ready stays high; writes to indexes of five and up are dropped.
module extension_pattern_classifier import epc_pkg::*; #(
  parameter int NUM_PATTERNS    = 5,
  parameter int MAX_PATTERN_LEN = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  localparam int CELLS = (MAX_PATTERN_LEN < PAT_BYTES) ? MAX_PATTERN_LEN : PAT_BYTES;

  logic [NUM_PATTERNS-1:0][PAT_W-1:0] pats;
  logic [NUM_PATTERNS-1:0][LEN_W-1:0] lens;

  assign cfg_ready = 1'b1;

  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_pat
    if (g < CFG_COUNT) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          pats[g] <= PATTERN_RESET[g];
        end else if (cfg_valid && cfg_index == CFG_IDX_W'(g)) begin
          pats[g] <= cfg_data;
        end
      end
    end else begin : g_empty
      always_ff @(posedge clk) begin
        pats[g] <= '0;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      lens[p] = pat_len(pats[p], LEN_W'(CELLS));
    end
  end

  logic              accept;
  logic [BYTE_W-1:0] c;
  logic              is_dot;
  logic              dot_seen;
  logic              fresh;
  logic              active;

  assign accept = in_valid && in_ready;
  assign c      = fold(in_data.char_in);
  assign is_dot = (c == DOT_CHAR);
  assign fresh  = !dot_seen && is_dot;
  assign active = dot_seen || is_dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_seen <= 1'b0;
    end else if (accept) begin
      dot_seen <= in_data.is_last ? 1'b0 : active;
    end
  end

  logic [CELLS-1:0][BYTE_W-1:0]       cell_byte;
  logic [CELLS-1:0]                   cell_valid;
  logic [CELLS-1:0][NUM_PATTERNS-1:0] cell_eq;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    logic              valid_in;
    if (j == 0) begin : g_head
      assign byte_in  = c;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = cell_byte[j-1];
      assign valid_in = cell_valid[j-1] && !fresh;
    end
    epc_cell #(
      .POS     (j),
      .NUM_PAT (NUM_PATTERNS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (accept && active),
      .byte_in   (byte_in),
      .valid_in  (valid_in),
      .pats      (pats),
      .lens      (lens),
      .byte_out  (cell_byte[j]),
      .valid_out (cell_valid[j]),
      .eq        (cell_eq[j])
    );
  end

  logic                    s_valid;
  logic                    s_active;
  logic                    s_last;
  logic                    s_go;
  logic [NUM_PATTERNS-1:0] hits;
  logic [NUM_PATTERNS-1:0] flags;
  logic [NUM_PATTERNS-1:0] flags_next;
  out_item_t               result;

  assign s_go     = !s_last || !out_valid || out_ready;
  assign in_ready = !s_valid || s_go;

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      hits[p] = (lens[p] != '0);
      for (int j = 0; j < CELLS; j++) begin
        hits[p] = hits[p] && cell_eq[j][p];
      end
    end
  end

  assign flags_next = flags | (s_active ? hits : '0);

  always_comb begin
    result.found        = 1'b0;
    result.format_index = '0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (flags_next[i]) begin
        result.found        = 1'b1;
        result.format_index = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      s_active  <= 1'b0;
      s_last    <= 1'b0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (s_valid && s_go) begin
        flags <= s_last ? '0 : flags_next;
        if (s_last) begin
          out_valid <= 1'b1;
        end
      end
      if (accept) begin
        s_valid  <= 1'b1;
        s_active <= active;
        s_last   <= in_data.is_last;
      end else if (s_go) begin
        s_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_go && s_last) begin
      out_data <= result;
    end
  end

endmodule

// ----- design/epc_cell.sv -----
// One window cell: holds one lowercased path byte and its valid bit, hands both on.
// Compares its byte against every pattern at its position; depends on epc_pkg.
module epc_cell import epc_pkg::*; #(
  parameter int POS     = 0,
  parameter int NUM_PAT = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift_en,
  input  logic [BYTE_W-1:0]              byte_in,
  input  logic                           valid_in,
  input  logic [NUM_PAT-1:0][PAT_W-1:0]  pats,
  input  logic [NUM_PAT-1:0][LEN_W-1:0]  lens,
  output logic [BYTE_W-1:0]              byte_out,
  output logic                           valid_out,
  output logic [NUM_PAT-1:0]             eq
);

  logic [BYTE_W-1:0] win_byte;
  logic              valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_byte <= byte_in;
    end
  end

  always_comb begin
    logic [LEN_W-1:0]  sel;
    logic [BYTE_W-1:0] pc;
    for (int p = 0; p < NUM_PAT; p++) begin
      sel = lens[p] - LEN_W'(1) - LEN_W'(POS);
      pc  = fold(pats[p][sel[1:0]*BYTE_W +: BYTE_W]);
      if (LEN_W'(POS) >= lens[p]) begin
        eq[p] = 1'b1;
      end else begin
        eq[p] = valid && (win_byte == pc);
      end
    end
  end

  assign byte_out  = win_byte;
  assign valid_out = valid;

endmodule

// ----- design/epc_checker.sv -----
// Port-level checks for extension_pattern_classifier, attached by bind.
// Depends on epc_pkg for the item types.
module epc_checker import epc_pkg::*; #(
  parameter int NUM_PATTERNS = 5
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out item changed while stalled");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.is_last, 2))
    else $error("out item without a last input item two cycles before");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(out_data.format_index) < NUM_PATTERNS)
    else $error("format_index beyond pattern count");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.format_index == '0)
    else $error("format_index set without found");

endmodule

bind extension_pattern_classifier epc_checker #(
  .NUM_PATTERNS (NUM_PATTERNS)
) u_epc_checker (.*);
